>>> sv/hsfc_pkg.sv
`timescale 1ns / 1ps
// shared types, class codes and constants for the half/single converter
// no dependencies

package hsfc_pkg;

    // operand class, decided in the decode stage
    typedef enum logic [2:0] {
        CLS_ZERO    = 3'd0,
        CLS_SUB     = 3'd1,
        CLS_NORM    = 3'd2,
        CLS_SPECIAL = 3'd3,
        CLS_OVF     = 3'd4,
        CLS_TINY    = 3'd5
    } cls_t;

    localparam logic [4:0] HALF_EXP_MAX     = 5'h1F;
    localparam logic [7:0] SINGLE_EXP_MAX   = 8'hFF;
    localparam logic [7:0] SINGLE_OVF_LIMIT = 8'd142;
    localparam logic [7:0] SINGLE_SUB_LOW   = 8'd102;
    localparam logic [7:0] SINGLE_NORM_LOW  = 8'd113;
    localparam logic [7:0] SUB_SHIFT_BASE   = 8'd126;
    localparam logic [7:0] EXP_BIAS_DIFF    = 8'd112;
    localparam logic [7:0] H2S_SUB_EXP_BASE = 8'd113;
    localparam logic [14:0] HALF_INF        = 15'h7C00;
    localparam logic [23:0] ROUND_BIAS      = 24'h000FFF;

    // decode stage payload
    typedef struct packed {
        logic        mode;
        logic        sign;
        cls_t        cls;
        logic        nan;
        logic [7:0]  exp;
        logic [22:0] man;
        logic [4:0]  shamt;
    } s1_t;

    // round stage payload
    typedef struct packed {
        logic        mode;
        logic        sign;
        cls_t        cls;
        logic        nan;
        logic [7:0]  exp;
        logic [3:0]  lz;
        logic [23:0] rnd;
    } s2_t;

    // leading zero count of a half mantissa, plus one for the hidden bit
    function automatic logic [3:0] hsfc_lz(input logic [9:0] m);
        logic [3:0] n;
        n = 4'd10;
        for (int i = 0; i < 10; i++) begin
            if (m[i]) begin
                n = 4'(10 - i);
            end
        end
        return n;
    endfunction

endpackage

>>> sv/hsfc_decode.sv
`timescale 1ns / 1ps
// decode stage: field split, operand class and shift amount
// depends on hsfc_pkg

module hsfc_decode (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           in_mode,
    input  logic [31:0]    in_operand,
    output logic           out_valid,
    input  logic           out_ready,
    output hsfc_pkg::s1_t  out_data
);
    import hsfc_pkg::*;

    logic       valid_reg;
    s1_t        data_reg;
    s1_t        data_next;
    logic [4:0] h_exp;
    logic [9:0] h_man;

    assign h_exp = in_operand[14:10];
    assign h_man = in_operand[9:0];

    always_comb begin
        data_next       = '0;
        data_next.mode  = in_mode;
        if (!in_mode) begin
            data_next.sign  = in_operand[15];
            data_next.exp   = {3'b000, h_exp};
            data_next.man   = {13'b0, h_man};
            data_next.nan   = 1'b0;
            data_next.shamt = {1'b0, hsfc_lz(h_man)};
            if (h_exp == 5'd0) begin
                data_next.cls = (h_man == 10'd0) ? CLS_ZERO : CLS_SUB;
            end else if (h_exp == HALF_EXP_MAX) begin
                data_next.cls = CLS_SPECIAL;
            end else begin
                data_next.cls = CLS_NORM;
            end
        end else begin
            data_next.sign  = in_operand[31];
            data_next.exp   = in_operand[30:23];
            data_next.man   = in_operand[22:0];
            data_next.nan   = |in_operand[22:0];
            data_next.shamt = 5'(SUB_SHIFT_BASE - in_operand[30:23]);
            if (in_operand[30:23] == SINGLE_EXP_MAX) begin
                data_next.cls = CLS_SPECIAL;
            end else if (in_operand[30:23] > SINGLE_OVF_LIMIT) begin
                data_next.cls = CLS_OVF;
            end else if (in_operand[30:23] < SINGLE_SUB_LOW) begin
                data_next.cls = CLS_TINY;
            end else if (in_operand[30:23] < SINGLE_NORM_LOW) begin
                data_next.cls = CLS_SUB;
            end else begin
                data_next.cls = CLS_NORM;
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

`ifndef ASSERT_OFF
    a_dec_inf_class: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready && in_mode && (in_operand[30:23] == SINGLE_EXP_MAX)
        |=> valid_reg && (data_reg.cls == CLS_SPECIAL))
        else $error("single inf/nan not classed as special");
`endif

endmodule

>>> sv/hsfc_round.sv
`timescale 1ns / 1ps
// round stage: rounding add, subnormal shift and half renormalisation
// depends on hsfc_pkg

module hsfc_round (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  hsfc_pkg::s1_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output hsfc_pkg::s2_t  out_data
);
    import hsfc_pkg::*;

    logic        valid_reg;
    s2_t         data_reg;
    s2_t         data_next;
    logic [24:0] sub_bias;
    logic [24:0] sub_sum;
    logic [10:0] sub_val;
    logic [23:0] nrm_sum;
    logic [10:0] h_norm;

    // single subnormal: half-up bias then shift right
    assign sub_bias = 25'd1 << (in_data.shamt - 5'd1);
    assign sub_sum  = {2'b01, in_data.man} + sub_bias;
    assign sub_val  = 11'(sub_sum >> in_data.shamt);

    // single normal: round to nearest even on bit 13
    assign nrm_sum  = {1'b0, in_data.man} + ROUND_BIAS + {23'b0, in_data.man[13]};

    // half subnormal: move leading one up to the hidden position
    assign h_norm   = {1'b0, in_data.man[9:0]} << in_data.shamt[3:0];

    always_comb begin
        data_next.mode = in_data.mode;
        data_next.sign = in_data.sign;
        data_next.cls  = in_data.cls;
        data_next.nan  = in_data.nan;
        data_next.exp  = in_data.exp;
        data_next.lz   = in_data.shamt[3:0];
        if (in_data.mode) begin
            data_next.rnd = (in_data.cls == CLS_SUB) ? {13'b0, sub_val} : nrm_sum;
        end else begin
            data_next.rnd = (in_data.cls == CLS_SUB) ? {14'b0, h_norm[9:0]}
                                                     : {14'b0, in_data.man[9:0]};
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

`ifndef ASSERT_OFF
    a_rnd_sub_range: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready && in_data.mode && (in_data.cls == CLS_SUB)
        |=> data_reg.rnd <= 24'h000400)
        else $error("half subnormal rounding beyond smallest normal");
`endif

endmodule

>>> sv/hsfc_pack.sv
`timescale 1ns / 1ps
// pack stage: exponent adjust, overflow after rounding, result assembly
// depends on hsfc_pkg; holds the output register

module hsfc_pack (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  hsfc_pkg::s2_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [31:0]    out_result
);
    import hsfc_pkg::*;

    logic        valid_reg;
    logic [31:0] result_reg;
    logic [31:0] result_next;
    logic [7:0]  h2s_sub_exp;
    logic [7:0]  h2s_norm_exp;
    logic        carry;
    logic [7:0]  s2h_exp;
    logic        s2h_ovf;

    assign h2s_sub_exp  = H2S_SUB_EXP_BASE - {4'b0, in_data.lz};
    assign h2s_norm_exp = in_data.exp + EXP_BIAS_DIFF;
    assign carry        = in_data.rnd[23];
    assign s2h_exp      = in_data.exp - EXP_BIAS_DIFF + {7'b0, carry};
    assign s2h_ovf      = carry && (in_data.exp == SINGLE_OVF_LIMIT);

    always_comb begin
        if (!in_data.mode) begin
            case (in_data.cls)
                CLS_ZERO:    result_next = {in_data.sign, 31'b0};
                CLS_SUB:     result_next = {in_data.sign, h2s_sub_exp,
                                            in_data.rnd[9:0], 13'b0};
                CLS_SPECIAL: result_next = {in_data.sign, SINGLE_EXP_MAX,
                                            in_data.rnd[9:0], 13'b0};
                default:     result_next = {in_data.sign, h2s_norm_exp,
                                            in_data.rnd[9:0], 13'b0};
            endcase
        end else begin
            case (in_data.cls)
                CLS_SPECIAL: result_next = {16'b0, in_data.sign, HALF_EXP_MAX,
                                            in_data.nan, 9'b0};
                CLS_OVF:     result_next = {16'b0, in_data.sign, HALF_INF};
                CLS_TINY:    result_next = {16'b0, in_data.sign, 15'b0};
                CLS_SUB:     result_next = {16'b0, in_data.sign, 4'b0, in_data.rnd[10:0]};
                default: begin
                    if (s2h_ovf) begin
                        result_next = {16'b0, in_data.sign, HALF_INF};
                    end else begin
                        result_next = {16'b0, in_data.sign, s2h_exp[4:0],
                                       carry ? 10'b0 : in_data.rnd[22:13]};
                    end
                end
            endcase
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            result_reg <= result_next;
        end
    end

`ifndef ASSERT_OFF
    a_pack_half_upper: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready && in_data.mode |=> result_reg[31:16] == 16'b0)
        else $error("half result with upper bits set");
    a_pack_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready && in_data.mode && (in_data.cls == CLS_OVF)
        |=> result_reg[14:0] == HALF_INF)
        else $error("overflow not mapped to infinity");
`endif

endmodule

>>> sv/half_single_float_converter.sv
`timescale 1ns / 1ps
// top level of the binary16 / binary32 converter: decode, round, pack stages
// depends on hsfc_pkg, hsfc_decode, hsfc_round, hsfc_pack
//
//   channel  dir  handshake          payload
//   s_       in   s_valid, s_ready   s_mode, s_operand[31:0]
//   m_       out  m_valid, m_ready   m_result[31:0]
//
// three register stages; an item passes the decode, round and pack registers in turn, the last driving m_result
// one item per cycle sustained while m_ready stays high
// each stage holds its item while the next one is full and stalled
// aresetn (synchronous) empties all stages

module half_single_float_converter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [31:0] s_operand,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_result
);
    import hsfc_pkg::*;

    logic s1_valid;
    logic s1_ready;
    s1_t  s1_data;
    logic s2_valid;
    logic s2_ready;
    s2_t  s2_data;

    hsfc_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_mode    (s_mode),
        .in_operand (s_operand),
        .out_valid  (s1_valid),
        .out_ready  (s1_ready),
        .out_data   (s1_data)
    );

    hsfc_round u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    hsfc_pack u_pack (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s2_valid),
        .in_ready   (s2_ready),
        .in_data    (s2_data),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_result (m_result)
    );

`ifndef ASSERT_OFF
    a_top_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s1_valid && !s2_valid)
        else $error("pipeline not empty after reset");
    a_top_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid && !s1_ready |=> s1_valid && $stable(s1_data))
        else $error("decode stage item lost under stall");
`endif

endmodule
